// ----- src/jsu_pkg.sv -----
// ----------------------------------------------------------------------------
// jsu_pkg: shared types and constants for the JSON string unescaper
// Decoder modes, error codes, the command passed from the front decoder to
// the result sequencer, and the queue status group.
// ----------------------------------------------------------------------------
package jsu_pkg;

  localparam int COUNT_WIDTH_DEF = 16;
  localparam int CFG_W           = 16;
  localparam logic [CFG_W-1:0] MAX_OUT_RST = 16'hFFFF;

  // Depth of the command queue between the front and back parts.
  localparam int QDEPTH = 4;
  localparam int QPTR_W = $clog2(QDEPTH);

  typedef enum logic [2:0] {
    MODE_IDLE,
    MODE_TEXT,
    MODE_UTF8,
    MODE_ESC,
    MODE_HEX1,
    MODE_SURR_BS,
    MODE_SURR_U,
    MODE_HEX2
  } mode_t;

  typedef enum logic [2:0] {
    ERR_OK   = 3'd0,
    ERR_UTF8 = 3'd1,
    ERR_CTRL = 3'd2,
    ERR_ESC  = 3'd3,
    ERR_UNI  = 3'd4,
    ERR_FULL = 3'd5,
    ERR_END  = 3'd6
  } err_t;

  // What one input byte asks the decoder to do.
  typedef enum logic [2:0] {
    ACT_NONE,
    ACT_MOVE,
    ACT_BYTE,
    ACT_CP,
    ACT_TERM,
    ACT_FAIL
  } act_t;

  // One item's worth of results: up to four data bytes, then an optional
  // closing result (terminator or error) that carries done.
  typedef struct packed {
    logic [2:0]      nbytes;
    logic [3:0][7:0] bytes;
    logic            tail;
    err_t            tail_err;
  } cmd_t;

  typedef struct packed {
    logic full;
    logic empty;
  } q_stat_t;

endpackage

// ----- src/json_string_unescape.sv -----
// ----------------------------------------------------------------------------
// json_string_unescape: streaming JSON string body decoder to UTF-8
// Feed the bytes after the opening quote one per item; decoded bytes come
// out one per result, ending in a NUL terminator or an error with done.
// ----------------------------------------------------------------------------
// Input channel: in_valid/in_ready with in_data_byte, in_starts_string and
// in_ends_data. A byte with in_starts_string begins a new string; bytes seen
// while no string is open are dropped without a result.
// Result channel: out_valid/out_ready with out_byte, out_error_code and
// out_done_res. Configuration: cfg_valid/cfg_ready (always ready) writes the
// output capacity cfg_max_out_bytes, counting the terminator.
// Each byte's command passes through the queue to the output register. The
// decoder takes one byte per cycle while the queue has room; the result side
// issues one result per cycle unless the output stalls, so a \u escape that
// encodes to k bytes gives k results, and the four-entry command queue absorbs
// such bursts before in_ready drops. When out_ready is low, the output
// register holds and the queue fills, then the input stalls. Reset empties
// the queue, closes any open string and sets the capacity to 65535.
// ----------------------------------------------------------------------------
module json_string_unescape #(
  parameter int COUNT_WIDTH = jsu_pkg::COUNT_WIDTH_DEF
) (
  input  logic                      clk,
  input  logic                      rst_n,
  input  logic                      cfg_valid,
  output logic                      cfg_ready,
  input  logic [jsu_pkg::CFG_W-1:0] cfg_max_out_bytes,
  input  logic                      in_valid,
  output logic                      in_ready,
  input  logic [7:0]                in_data_byte,
  input  logic                      in_starts_string,
  input  logic                      in_ends_data,
  output logic                      out_valid,
  input  logic                      out_ready,
  output logic [7:0]                out_byte,
  output logic [2:0]                out_error_code,
  output logic                      out_done_res
);

  logic [jsu_pkg::CFG_W-1:0] max_r, max_nxt;
  logic             q_push, q_pop;
  jsu_pkg::cmd_t    q_din, q_dout;
  jsu_pkg::q_stat_t q_stat;

  assign cfg_ready = 1'b1;
  assign max_nxt   = (cfg_valid && cfg_ready) ? cfg_max_out_bytes : max_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      max_r <= jsu_pkg::MAX_OUT_RST;
    end else begin
      max_r <= max_nxt;
    end
  end

  jsu_front #(.COUNT_WIDTH(COUNT_WIDTH)) u_front (
    .clk              (clk),
    .rst_n            (rst_n),
    .max_out_bytes    (max_r),
    .q_full           (q_stat.full),
    .in_valid         (in_valid),
    .in_ready         (in_ready),
    .in_data_byte     (in_data_byte),
    .in_starts_string (in_starts_string),
    .in_ends_data     (in_ends_data),
    .push             (q_push),
    .cmd              (q_din)
  );

  jsu_queue u_queue (
    .clk   (clk),
    .rst_n (rst_n),
    .push  (q_push),
    .din   (q_din),
    .pop   (q_pop),
    .dout  (q_dout),
    .stat  (q_stat)
  );

  jsu_back u_back (
    .clk            (clk),
    .rst_n          (rst_n),
    .head           (q_dout),
    .q_stat         (q_stat),
    .pop            (q_pop),
    .out_valid      (out_valid),
    .out_ready      (out_ready),
    .out_byte       (out_byte),
    .out_error_code (out_error_code),
    .out_done_res   (out_done_res)
  );

  // The decoder never writes a command into a full queue.
  a_no_push_full: assert property (@(posedge clk) disable iff (!rst_n)
    q_push |-> !q_stat.full)
    else $error("command pushed into full queue");

  a_stat_sane: assert property (@(posedge clk) disable iff (!rst_n)
    !(q_stat.full && q_stat.empty))
    else $error("queue reports full and empty");

  // An error result always closes the string and carries a zero byte.
  a_err_done: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_error_code != jsu_pkg::ERR_OK) |-> (out_done_res && out_byte == 8'h00))
    else $error("error result without done or with data");

  a_done_zero: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_done_res) |-> (out_byte == 8'h00))
    else $error("closing result carries a nonzero byte");

endmodule

// ----- src/jsu_front.sv -----
// ----------------------------------------------------------------------------
// jsu_front: byte classifier and decoder state
// Takes one string byte per cycle while the queue has room, tracks escapes,
// hex digits, surrogates, UTF-8 continuation and the output byte count, and
// pushes one command per byte that produces results.
// ----------------------------------------------------------------------------
module jsu_front #(
  parameter int COUNT_WIDTH = jsu_pkg::COUNT_WIDTH_DEF
) (
  input  logic                     clk,
  input  logic                     rst_n,
  input  logic [jsu_pkg::CFG_W-1:0] max_out_bytes,
  input  logic                     q_full,
  input  logic                     in_valid,
  output logic                     in_ready,
  input  logic [7:0]               in_data_byte,
  input  logic                     in_starts_string,
  input  logic                     in_ends_data,
  output logic                     push,
  output jsu_pkg::cmd_t            cmd
);

  function automatic logic [4:0] hex_digit(input logic [7:0] b);
    logic [4:0] r;
    r = 5'd0;
    if (b >= 8'h30 && b <= 8'h39) r = {1'b1, 4'(b - 8'h30)};
    else if (b >= 8'h41 && b <= 8'h46) r = {1'b1, 4'(b - 8'h37)};
    else if (b >= 8'h61 && b <= 8'h66) r = {1'b1, 4'(b - 8'h57)};
    return r;
  endfunction

  function automatic logic [8:0] esc_byte(input logic [7:0] b);
    logic [8:0] r;
    r = 9'd0;
    case (b)
      8'h22:   r = {1'b1, 8'h22};
      8'h5C:   r = {1'b1, 8'h5C};
      8'h2F:   r = {1'b1, 8'h2F};
      8'h62:   r = {1'b1, 8'h08};
      8'h66:   r = {1'b1, 8'h0C};
      8'h6E:   r = {1'b1, 8'h0A};
      8'h72:   r = {1'b1, 8'h0D};
      8'h74:   r = {1'b1, 8'h09};
      default: r = 9'd0;
    endcase
    return r;
  endfunction

  function automatic logic [2:0] lead_len(input logic [7:0] b);
    logic [2:0] r;
    r = 3'd0;
    if (b == 8'hC0 || b == 8'hC1 || b >= 8'hF5) r = 3'd0;
    else if (b[7:5] == 3'b110) r = 3'd2;
    else if (b[7:4] == 4'b1110) r = 3'd3;
    else if (b[7:3] == 5'b11110) r = 3'd4;
    return r;
  endfunction

  function automatic logic [3:0][7:0] utf8_enc(input logic [20:0] cp, input logic [2:0] k);
    logic [3:0][7:0] r;
    r = '0;
    case (k)
      3'd1: r[0] = cp[7:0];
      3'd2: begin
        r[0] = {3'b110, cp[10:6]};
        r[1] = {2'b10, cp[5:0]};
      end
      3'd3: begin
        r[0] = {4'b1110, cp[15:12]};
        r[1] = {2'b10, cp[11:6]};
        r[2] = {2'b10, cp[5:0]};
      end
      default: begin
        r[0] = {5'b11110, cp[20:18]};
        r[1] = {2'b10, cp[17:12]};
        r[2] = {2'b10, cp[11:6]};
        r[3] = {2'b10, cp[5:0]};
      end
    endcase
    return r;
  endfunction

  jsu_pkg::mode_t mode_r, mode_nxt, mode_e, go;
  logic [COUNT_WIDTH-1:0] bw_r, bw_nxt, bw_e, cap;
  logic [15:0] hex_r, hex_nxt, hex_e, hex_go, acc;
  logic [1:0]  cnt_r, cnt_nxt, cnt_e, cnt_go;
  logic [9:0]  hs_r, hs_nxt, hs_e, hs_go;
  logic [1:0]  rem_r, rem_nxt, rem_e, rem_go;

  jsu_pkg::act_t act;
  jsu_pkg::err_t act_err, fail_err;
  logic [7:0]  byte_v;
  logic [20:0] cp;
  logic [2:0]  k, len;
  logic [4:0]  hv;
  logic [8:0]  ev;
  logic        fire, live, room1, roomk, ok, fail_now, writes;

  assign in_ready = !q_full;
  assign fire     = in_valid && in_ready;

  // A start byte sees the cleared decoder.
  always_comb begin
    mode_e = in_starts_string ? jsu_pkg::MODE_TEXT : mode_r;
    bw_e   = in_starts_string ? '0 : bw_r;
    hex_e  = in_starts_string ? '0 : hex_r;
    cnt_e  = in_starts_string ? '0 : cnt_r;
    hs_e   = in_starts_string ? '0 : hs_r;
    rem_e  = in_starts_string ? '0 : rem_r;
  end

  assign live = fire && (mode_e != jsu_pkg::MODE_IDLE);
  assign hv   = hex_digit(in_data_byte);
  assign ev   = esc_byte(in_data_byte);
  assign len  = lead_len(in_data_byte);
  assign acc  = {hex_e[11:0], hv[3:0]};

  always_comb begin
    act    = jsu_pkg::ACT_NONE;
    act_err = jsu_pkg::ERR_OK;
    byte_v = in_data_byte;
    cp     = '0;
    go     = mode_e;
    hex_go = hex_e;
    cnt_go = cnt_e;
    hs_go  = hs_e;
    rem_go = rem_e;
    unique case (mode_e)
      jsu_pkg::MODE_IDLE: act = jsu_pkg::ACT_NONE;
      jsu_pkg::MODE_TEXT: begin
        if (in_data_byte == 8'h22) begin
          act = jsu_pkg::ACT_TERM;
        end else if (in_data_byte == 8'h5C) begin
          act = jsu_pkg::ACT_MOVE;
          go  = jsu_pkg::MODE_ESC;
        end else if (in_data_byte <= 8'h1F) begin
          act     = jsu_pkg::ACT_FAIL;
          act_err = jsu_pkg::ERR_CTRL;
        end else if (!in_data_byte[7]) begin
          act = jsu_pkg::ACT_BYTE;
        end else if (len == 3'd0 || in_ends_data) begin
          act     = jsu_pkg::ACT_FAIL;
          act_err = jsu_pkg::ERR_UTF8;
        end else begin
          act    = jsu_pkg::ACT_BYTE;
          go     = jsu_pkg::MODE_UTF8;
          rem_go = 2'(len - 3'd1);
        end
      end
      jsu_pkg::MODE_UTF8: begin
        if (in_data_byte[7:6] != 2'b10 || (in_ends_data && rem_e > 2'd1)) begin
          act     = jsu_pkg::ACT_FAIL;
          act_err = jsu_pkg::ERR_UTF8;
        end else begin
          act    = jsu_pkg::ACT_BYTE;
          rem_go = rem_e - 2'd1;
          go     = (rem_e == 2'd1) ? jsu_pkg::MODE_TEXT : jsu_pkg::MODE_UTF8;
        end
      end
      jsu_pkg::MODE_ESC: begin
        if (in_data_byte == 8'h75) begin
          act    = jsu_pkg::ACT_MOVE;
          go     = jsu_pkg::MODE_HEX1;
          hex_go = '0;
          cnt_go = '0;
        end else if (ev[8]) begin
          act    = jsu_pkg::ACT_BYTE;
          byte_v = ev[7:0];
          go     = jsu_pkg::MODE_TEXT;
        end else begin
          act     = jsu_pkg::ACT_FAIL;
          act_err = jsu_pkg::ERR_ESC;
        end
      end
      jsu_pkg::MODE_SURR_BS: begin
        if (in_data_byte == 8'h5C) begin
          act = jsu_pkg::ACT_MOVE;
          go  = jsu_pkg::MODE_SURR_U;
        end else begin
          act     = jsu_pkg::ACT_FAIL;
          act_err = jsu_pkg::ERR_UNI;
        end
      end
      jsu_pkg::MODE_SURR_U: begin
        if (in_data_byte == 8'h75) begin
          act    = jsu_pkg::ACT_MOVE;
          go     = jsu_pkg::MODE_HEX2;
          hex_go = '0;
          cnt_go = '0;
        end else begin
          act     = jsu_pkg::ACT_FAIL;
          act_err = jsu_pkg::ERR_UNI;
        end
      end
      jsu_pkg::MODE_HEX1, jsu_pkg::MODE_HEX2: begin
        if (!hv[4]) begin
          act     = jsu_pkg::ACT_FAIL;
          act_err = jsu_pkg::ERR_UNI;
        end else begin
          hex_go = acc;
          if (cnt_e != 2'd3) begin
            act    = jsu_pkg::ACT_MOVE;
            cnt_go = cnt_e + 2'd1;
          end else begin
            cnt_go = '0;
            if (mode_e == jsu_pkg::MODE_HEX1) begin
              if (acc[15:10] == 6'b110110) begin
                act   = jsu_pkg::ACT_MOVE;
                go    = jsu_pkg::MODE_SURR_BS;
                hs_go = acc[9:0];
              end else if (acc[15:10] == 6'b110111) begin
                act     = jsu_pkg::ACT_FAIL;
                act_err = jsu_pkg::ERR_UNI;
              end else begin
                act = jsu_pkg::ACT_CP;
                cp  = {5'd0, acc};
                go  = jsu_pkg::MODE_TEXT;
              end
            end else if (acc[15:10] != 6'b110111) begin
              act     = jsu_pkg::ACT_FAIL;
              act_err = jsu_pkg::ERR_UNI;
            end else begin
              act = jsu_pkg::ACT_CP;
              cp  = 21'h10000 + {1'b0, hs_e, acc[9:0]};
              go  = jsu_pkg::MODE_TEXT;
            end
          end
        end
      end
      default: act = jsu_pkg::ACT_NONE;
    endcase
  end

  always_comb begin
    if (cp < 21'h80) k = 3'd1;
    else if (cp < 21'h800) k = 3'd2;
    else if (cp < 21'h10000) k = 3'd3;
    else k = 3'd4;
  end

  // Usable capacity is the register clipped to what the counter can hold.
  always_comb begin
    if (COUNT_WIDTH >= jsu_pkg::CFG_W) cap = COUNT_WIDTH'(max_out_bytes);
    else if ((max_out_bytes >> COUNT_WIDTH) != '0) cap = '1;
    else cap = COUNT_WIDTH'(max_out_bytes);
  end

  assign room1 = ({1'b0, bw_e} + (COUNT_WIDTH+1)'(1)) <= {1'b0, cap};
  assign roomk = ({1'b0, bw_e} + (COUNT_WIDTH+1)'(k)) <= {1'b0, cap};
  assign writes = (act == jsu_pkg::ACT_BYTE) || (act == jsu_pkg::ACT_TERM) ||
                  (act == jsu_pkg::ACT_CP);
  assign ok = (act == jsu_pkg::ACT_CP) ? roomk : room1;
  assign fail_now = (act == jsu_pkg::ACT_FAIL) || (writes && !ok);
  assign fail_err = (act == jsu_pkg::ACT_FAIL) ? act_err : jsu_pkg::ERR_FULL;

  // Next mode.
  always_comb begin
    mode_nxt = mode_r;
    if (live) begin
      if (fail_now || act == jsu_pkg::ACT_TERM) mode_nxt = jsu_pkg::MODE_IDLE;
      else if (in_ends_data) mode_nxt = jsu_pkg::MODE_IDLE;
      else mode_nxt = go;
    end
  end

  // Command for the back part.
  always_comb begin
    cmd = '0;
    cmd.tail_err = jsu_pkg::ERR_OK;
    if (fail_now) begin
      cmd.tail     = 1'b1;
      cmd.tail_err = fail_err;
    end else if (act == jsu_pkg::ACT_TERM) begin
      cmd.tail = 1'b1;
    end else begin
      if (act == jsu_pkg::ACT_BYTE) begin
        cmd.nbytes   = 3'd1;
        cmd.bytes[0] = byte_v;
      end else if (act == jsu_pkg::ACT_CP) begin
        cmd.nbytes = k;
        cmd.bytes  = utf8_enc(cp, k);
      end
      if (in_ends_data) begin
        cmd.tail     = 1'b1;
        cmd.tail_err = jsu_pkg::ERR_END;
      end
    end
    push = live && (cmd.nbytes != 3'd0 || cmd.tail);
  end

  always_comb begin
    bw_nxt  = bw_r;
    hex_nxt = hex_r;
    cnt_nxt = cnt_r;
    hs_nxt  = hs_r;
    rem_nxt = rem_r;
    if (live) begin
      bw_nxt  = (writes && !fail_now) ?
                bw_e + ((act == jsu_pkg::ACT_CP) ? COUNT_WIDTH'(k) : COUNT_WIDTH'(1)) :
                bw_e;
      hex_nxt = hex_go;
      cnt_nxt = cnt_go;
      hs_nxt  = hs_go;
      rem_nxt = rem_go;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mode_r <= jsu_pkg::MODE_IDLE;
      bw_r   <= '0;
      hex_r  <= '0;
      cnt_r  <= '0;
      hs_r   <= '0;
      rem_r  <= '0;
    end else begin
      mode_r <= mode_nxt;
      bw_r   <= bw_nxt;
      hex_r  <= hex_nxt;
      cnt_r  <= cnt_nxt;
      hs_r   <= hs_nxt;
      rem_r  <= rem_nxt;
    end
  end

endmodule

// ----- src/jsu_queue.sv -----
// ----------------------------------------------------------------------------
// jsu_queue: short command queue
// A small register FIFO that lets the decoder and the result sequencer
// stall independently.
// ----------------------------------------------------------------------------
module jsu_queue (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              push,
  input  jsu_pkg::cmd_t     din,
  input  logic              pop,
  output jsu_pkg::cmd_t     dout,
  output jsu_pkg::q_stat_t  stat
);

  jsu_pkg::cmd_t mem_r [jsu_pkg::QDEPTH];
  logic [jsu_pkg::QPTR_W-1:0] wr_r, wr_nxt, rd_r, rd_nxt;
  logic [jsu_pkg::QPTR_W:0]   cnt_r, cnt_nxt;
  logic do_push, do_pop;

  assign stat.full  = (cnt_r == (jsu_pkg::QPTR_W+1)'(jsu_pkg::QDEPTH));
  assign stat.empty = (cnt_r == '0);
  assign do_push    = push && !stat.full;
  assign do_pop     = pop && !stat.empty;
  assign dout       = mem_r[rd_r];

  always_comb begin
    wr_nxt  = do_push ? wr_r + 1'b1 : wr_r;
    rd_nxt  = do_pop ? rd_r + 1'b1 : rd_r;
    cnt_nxt = cnt_r;
    if (do_push && !do_pop) cnt_nxt = cnt_r + 1'b1;
    else if (do_pop && !do_push) cnt_nxt = cnt_r - 1'b1;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_r  <= '0;
      rd_r  <= '0;
      cnt_r <= '0;
    end else begin
      wr_r  <= wr_nxt;
      rd_r  <= rd_nxt;
      cnt_r <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (do_push) mem_r[wr_r] <= din;
  end

endmodule

// ----- src/jsu_back.sv -----
// ----------------------------------------------------------------------------
// jsu_back: result sequencer
// Walks the command at the head of the queue and issues one result per
// cycle into the output register while that register is empty or out_ready is high.
// ----------------------------------------------------------------------------
module jsu_back (
  input  logic             clk,
  input  logic             rst_n,
  input  jsu_pkg::cmd_t    head,
  input  jsu_pkg::q_stat_t q_stat,
  output logic             pop,
  output logic             out_valid,
  input  logic             out_ready,
  output logic [7:0]       out_byte,
  output logic [2:0]       out_error_code,
  output logic             out_done_res
);

  logic [2:0] pos_r, pos_nxt, total;
  logic       valid_r, valid_nxt, load, last;
  logic [7:0] byte_r, byte_nxt;
  jsu_pkg::err_t err_r, err_nxt;
  logic       done_r, done_nxt;

  assign total = head.nbytes + {2'b00, head.tail};
  assign last  = (pos_r == total - 3'd1);
  assign load  = !q_stat.empty && (!valid_r || out_ready);
  assign pop   = load && last;

  always_comb begin
    pos_nxt   = pos_r;
    valid_nxt = valid_r && !out_ready;
    byte_nxt  = byte_r;
    err_nxt   = err_r;
    done_nxt  = done_r;
    if (load) begin
      valid_nxt = 1'b1;
      pos_nxt   = last ? 3'd0 : pos_r + 3'd1;
      // Data bytes first, then the closing result if the command has one.
      if (pos_r < head.nbytes) begin
        byte_nxt = head.bytes[pos_r[1:0]];
        err_nxt  = jsu_pkg::ERR_OK;
        done_nxt = 1'b0;
      end else begin
        byte_nxt = 8'h00;
        err_nxt  = head.tail_err;
        done_nxt = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pos_r   <= '0;
      valid_r <= 1'b0;
    end else begin
      pos_r   <= pos_nxt;
      valid_r <= valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    byte_r <= byte_nxt;
    err_r  <= err_nxt;
    done_r <= done_nxt;
  end

  assign out_valid      = valid_r;
  assign out_byte       = byte_r;
  assign out_error_code = err_r;
  assign out_done_res   = done_r;

endmodule

// ----- sim/json_string_unescape_checker.sv -----
// ----------------------------------------------------------------------------
// json_string_unescape_checker: result predictor and scoreboard
// Watches the configuration, input and result channels of the JSON string
// unescaper. It keeps its own copy of the decoder state and capacity, works
// out the decoded bytes each accepted item should give, and compares every
// accepted result with the oldest expected one.
// ----------------------------------------------------------------------------
module json_string_unescape_checker (
  input  logic                      clk,
  input  logic                      rst_n,
  input  logic                      cfg_valid,
  input  logic                      cfg_ready,
  input  logic [jsu_pkg::CFG_W-1:0] cfg_max_out_bytes,
  input  logic                      in_valid,
  input  logic                      in_ready,
  input  logic [7:0]                in_data_byte,
  input  logic                      in_starts_string,
  input  logic                      in_ends_data,
  input  logic                      out_valid,
  input  logic                      out_ready,
  input  logic [7:0]                out_byte,
  input  logic [2:0]                out_error_code,
  input  logic                      out_done_res,
  output int                        fail_count,
  output int                        pending,
  output int                        results_checked,
  output logic [7:0]                codes_seen
);
  timeunit 1ns;
  timeprecision 1ps;

  localparam logic [7:0] QUOTE     = 8'h22;
  localparam logic [7:0] BACKSLASH = 8'h5C;
  localparam logic [7:0] LETTER_U  = 8'h75;
  localparam logic [7:0] CTRL_MAX  = 8'h1F;
  localparam int         MAX_REPORTS = 10;

  typedef struct packed {
    logic [7:0]    data;
    jsu_pkg::err_t err;
    logic          done;
  } text_result_t;

  text_result_t expected_text[$];

  // Decoder state as the block should hold it.
  jsu_pkg::mode_t mode;
  logic [15:0] hex_acc;
  logic [1:0]  hex_cnt;
  logic [9:0]  hi_surr;
  logic [1:0]  utf8_left;
  int unsigned written;
  int unsigned capacity;

  int   n_fail = 0;
  int   n_reports = 0;
  int   n_checked = 0;
  logic [7:0] n_codes = '0;

  function automatic void clear_decoder(jsu_pkg::mode_t m);
    mode      = m;
    hex_acc   = '0;
    hex_cnt   = '0;
    hi_surr   = '0;
    utf8_left = '0;
    written   = 0;
  endfunction

  function automatic bit room_for(int unsigned k);
    return written + k <= capacity;
  endfunction

  function automatic void push_result(logic [7:0] data, jsu_pkg::err_t err, logic done);
    text_result_t r;
    r.data = data;
    r.err  = err;
    r.done = done;
    expected_text.push_back(r);
  endfunction

  // Any error closes the string with a single result.
  function automatic void give_up(jsu_pkg::err_t err);
    mode = jsu_pkg::MODE_IDLE;
    push_result(8'h00, err, 1'b1);
  endfunction

  function automatic void put_plain(logic [7:0] b);
    if (!room_for(1)) begin
      give_up(jsu_pkg::ERR_FULL);
      return;
    end
    written++;
    push_result(b, jsu_pkg::ERR_OK, 1'b0);
  endfunction

  // The whole encoding must fit, otherwise none of it is written.
  function automatic void put_code_point(logic [20:0] cp);
    int unsigned k;
    k = (cp < 21'h80) ? 1 : (cp < 21'h800) ? 2 : (cp < 21'h10000) ? 3 : 4;
    if (!room_for(k)) begin
      give_up(jsu_pkg::ERR_FULL);
      return;
    end
    case (k)
      1: push_result(cp[7:0], jsu_pkg::ERR_OK, 1'b0);
      2: begin
        push_result({3'b110, cp[10:6]}, jsu_pkg::ERR_OK, 1'b0);
        push_result({2'b10, cp[5:0]}, jsu_pkg::ERR_OK, 1'b0);
      end
      3: begin
        push_result({4'b1110, cp[15:12]}, jsu_pkg::ERR_OK, 1'b0);
        push_result({2'b10, cp[11:6]}, jsu_pkg::ERR_OK, 1'b0);
        push_result({2'b10, cp[5:0]}, jsu_pkg::ERR_OK, 1'b0);
      end
      default: begin
        push_result({5'b11110, cp[20:18]}, jsu_pkg::ERR_OK, 1'b0);
        push_result({2'b10, cp[17:12]}, jsu_pkg::ERR_OK, 1'b0);
        push_result({2'b10, cp[11:6]}, jsu_pkg::ERR_OK, 1'b0);
        push_result({2'b10, cp[5:0]}, jsu_pkg::ERR_OK, 1'b0);
      end
    endcase
    written += k;
    mode = jsu_pkg::MODE_TEXT;
  endfunction

  function automatic int hex_digit(logic [7:0] b);
    if (b >= 8'h30 && b <= 8'h39) return b - 8'h30;
    if (b >= 8'h41 && b <= 8'h46) return b - 8'h41 + 10;
    if (b >= 8'h61 && b <= 8'h66) return b - 8'h61 + 10;
    return -1;
  endfunction

  // Bit 8 set means the letter is not a valid single-byte escape.
  function automatic logic [8:0] escaped(logic [7:0] b);
    case (b)
      8'h22:   return 9'h022;
      8'h5C:   return 9'h05C;
      8'h2F:   return 9'h02F;
      8'h62:   return 9'h008;
      8'h66:   return 9'h00C;
      8'h6E:   return 9'h00A;
      8'h72:   return 9'h00D;
      8'h74:   return 9'h009;
      default: return 9'h100;
    endcase
  endfunction

  function automatic int lead_bytes(logic [7:0] b);
    if (b == 8'hC0 || b == 8'hC1 || b >= 8'hF5) return 0;
    if (b[7:5] == 3'b110) return 2;
    if (b[7:4] == 4'b1110) return 3;
    if (b[7:3] == 5'b11110) return 4;
    return 0;
  endfunction

  function automatic void unescape_byte(logic [7:0] b, logic first, logic last);
    int         digit;
    int         seq_len;
    logic [8:0] esc;
    if (first) clear_decoder(jsu_pkg::MODE_TEXT);
    if (mode == jsu_pkg::MODE_IDLE) return;
    case (mode)
      jsu_pkg::MODE_TEXT: begin
        if (b == QUOTE) begin
          if (room_for(1)) begin
            written++;
            mode = jsu_pkg::MODE_IDLE;
            push_result(8'h00, jsu_pkg::ERR_OK, 1'b1);
          end else begin
            give_up(jsu_pkg::ERR_FULL);
          end
        end else if (b == BACKSLASH) begin
          mode = jsu_pkg::MODE_ESC;
        end else if (b <= CTRL_MAX) begin
          give_up(jsu_pkg::ERR_CTRL);
        end else if (b < 8'h80) begin
          put_plain(b);
        end else begin
          seq_len = lead_bytes(b);
          // A lead byte on the last item can never be completed.
          if (seq_len == 0 || last) begin
            give_up(jsu_pkg::ERR_UTF8);
          end else begin
            put_plain(b);
            if (mode != jsu_pkg::MODE_IDLE) begin
              utf8_left = seq_len - 1;
              mode = jsu_pkg::MODE_UTF8;
            end
          end
        end
      end
      jsu_pkg::MODE_UTF8: begin
        if (b[7:6] != 2'b10 || (last && utf8_left > 1)) begin
          give_up(jsu_pkg::ERR_UTF8);
        end else begin
          put_plain(b);
          if (mode != jsu_pkg::MODE_IDLE) begin
            utf8_left = utf8_left - 1;
            if (utf8_left == 0) mode = jsu_pkg::MODE_TEXT;
          end
        end
      end
      jsu_pkg::MODE_ESC: begin
        if (b == LETTER_U) begin
          mode = jsu_pkg::MODE_HEX1;
          hex_acc = '0;
          hex_cnt = '0;
        end else begin
          esc = escaped(b);
          if (esc[8]) begin
            give_up(jsu_pkg::ERR_ESC);
          end else begin
            mode = jsu_pkg::MODE_TEXT;
            put_plain(esc[7:0]);
          end
        end
      end
      jsu_pkg::MODE_SURR_BS: begin
        if (b == BACKSLASH) mode = jsu_pkg::MODE_SURR_U;
        else give_up(jsu_pkg::ERR_UNI);
      end
      jsu_pkg::MODE_SURR_U: begin
        if (b == LETTER_U) begin
          mode = jsu_pkg::MODE_HEX2;
          hex_acc = '0;
          hex_cnt = '0;
        end else begin
          give_up(jsu_pkg::ERR_UNI);
        end
      end
      default: begin
        digit = hex_digit(b);
        if (digit < 0) begin
          give_up(jsu_pkg::ERR_UNI);
        end else begin
          hex_acc = {hex_acc[11:0], digit[3:0]};
          if (hex_cnt < 3) begin
            hex_cnt = hex_cnt + 1;
          end else begin
            hex_cnt = '0;
            if (mode == jsu_pkg::MODE_HEX1) begin
              if (hex_acc >= 16'hD800 && hex_acc < 16'hDC00) begin
                hi_surr = hex_acc[9:0];
                mode = jsu_pkg::MODE_SURR_BS;
              end else if (hex_acc >= 16'hDC00 && hex_acc < 16'hE000) begin
                give_up(jsu_pkg::ERR_UNI);
              end else begin
                put_code_point({5'd0, hex_acc});
              end
            end else if (hex_acc[15:10] != 6'b110111) begin
              give_up(jsu_pkg::ERR_UNI);
            end else begin
              put_code_point(21'h10000 + {1'b0, hi_surr, hex_acc[9:0]});
            end
          end
        end
      end
    endcase
    if (last && mode != jsu_pkg::MODE_IDLE) give_up(jsu_pkg::ERR_END);
  endfunction

  function automatic void check_result();
    text_result_t want;
    n_checked++;
    if (expected_text.size() == 0) begin
      n_fail++;
      if (n_reports < MAX_REPORTS) begin
        n_reports++;
        $display("[%0t] result %0d arrived with nothing expected: byte %02h code %0d done %0b",
                 $time, n_checked, out_byte, out_error_code, out_done_res);
      end
      return;
    end
    want = expected_text.pop_front();
    if (out_byte !== want.data || out_error_code !== want.err ||
        out_done_res !== want.done) begin
      n_fail++;
      if (n_reports < MAX_REPORTS) begin
        n_reports++;
        $display("[%0t] result %0d wrong: expected byte %02h code %0d done %0b, got %02h %0d %0b",
                 $time, n_checked, want.data, want.err, want.done,
                 out_byte, out_error_code, out_done_res);
      end
    end
    n_codes[want.err] = 1'b1;
  endfunction

  always @(posedge clk) begin
    if (!rst_n) begin
      clear_decoder(jsu_pkg::MODE_IDLE);
      capacity = jsu_pkg::MAX_OUT_RST;
      expected_text.delete();
    end else begin
      if (cfg_valid && cfg_ready) capacity = cfg_max_out_bytes;
      if (out_valid && out_ready) check_result();
      if (in_valid && in_ready) unescape_byte(in_data_byte, in_starts_string, in_ends_data);
    end
    // Published after the edge so the stimulus side reads settled values.
    pending         <= expected_text.size();
    fail_count      <= n_fail;
    results_checked <= n_checked;
    codes_seen      <= n_codes;
  end

endmodule

// ----- sim/testbench.sv -----
// ----------------------------------------------------------------------------
// testbench: stimulus and verdict for the JSON string unescaper
// Sends directed corner strings, then random well-formed strings with some
// broken ones mixed in, under several output capacities. Both channels idle
// at random; the checker beside the block predicts and compares results.
// ----------------------------------------------------------------------------
module testbench;
  timeunit 1ns;
  timeprecision 1ps;

  localparam logic [7:0] QUOTE     = 8'h22;
  localparam logic [7:0] BACKSLASH = 8'h5C;
  localparam logic [7:0] LETTER_U  = 8'h75;
  localparam int QUIET_LIMIT  = 2000;
  localparam int LONG_HOLD    = 300;
  localparam int SETTLE       = 8;
  localparam int TOTAL_ITEMS  = 370;

  logic        clk = 1'b0;
  logic        rst_n = 1'b0;
  logic        cfg_valid = 1'b0;
  logic        cfg_ready;
  logic [15:0] cfg_max_out_bytes = '0;
  logic        in_valid = 1'b0;
  logic        in_ready;
  logic [7:0]  in_data_byte = '0;
  logic        in_starts_string = 1'b0;
  logic        in_ends_data = 1'b0;
  logic        out_valid;
  logic        out_ready = 1'b0;
  logic [7:0]  out_byte;
  logic [2:0]  out_error_code;
  logic        out_done_res;

  int          fail_count;
  int          pending;
  int          results_checked;
  logic [7:0]  codes_seen;

  int   items_sent = 0;
  int   strings_sent = 0;
  int   settings_used = 0;
  int   burst_left = 0;
  bit   steady = 1'b0;
  int   hold_requests = 0;
  int   holds_done = 0;
  int   quiet_cycles = 0;
  logic [7:0] body[$];

  json_string_unescape u_dut (.*);

  json_string_unescape_checker u_checker (.*);

  initial begin
    forever #5 clk = ~clk;
  end

  always @(posedge clk) begin
    if ((in_valid && in_ready) || (out_valid && out_ready) || (cfg_valid && cfg_ready))
      quiet_cycles <= 0;
    else
      quiet_cycles <= quiet_cycles + 1;
    if (quiet_cycles >= QUIET_LIMIT) begin
      $display("[%0t] no item moved for %0d cycles", $time, QUIET_LIMIT);
      $display("json_string_unescape: mismatch");
      $finish;
    end
  end

  // Result side: segments of different readiness, plus a long hold-off
  // whenever the stimulus asks for one.
  initial begin : receiver
    int seg_left;
    int seg_kind;
    int pct;
    seg_left = 0;
    seg_kind = 0;
    forever begin
      @(posedge clk);
      if (hold_requests != holds_done) begin
        holds_done++;
        out_ready <= 1'b0;
        repeat (LONG_HOLD - 1) @(posedge clk);
      end else begin
        if (seg_left == 0) begin
          seg_kind = $urandom_range(0, 3);
          seg_left = $urandom_range(10, 80);
        end
        seg_left--;
        case (seg_kind)
          0:       pct = 100;
          1:       pct = 50;
          2:       pct = 85;
          default: pct = 20;
        endcase
        out_ready <= ($urandom_range(1, 100) <= pct);
      end
    end
  end

  task automatic send_item(input logic [7:0] b, input logic first, input logic last,
                           input bit counted);
    if (!steady && burst_left == 0) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 8)) @(posedge clk);
      burst_left = ($urandom_range(0, 3) == 0) ? 60 : $urandom_range(1, 12);
    end
    in_valid         <= 1'b1;
    in_data_byte     <= b;
    in_starts_string <= first;
    in_ends_data     <= last;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    if (burst_left > 0) burst_left--;
    if (counted) items_sent++;
  endtask

  // Stop offering items and let every outstanding result come out.
  task automatic wait_for_idle();
    in_valid <= 1'b0;
    @(posedge clk);
    while (pending != 0) @(posedge clk);
    repeat (SETTLE) @(posedge clk);
  endtask

  task automatic set_capacity(input logic [15:0] cap);
    wait_for_idle();
    cfg_valid         <= 1'b1;
    cfg_max_out_bytes <= cap;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    cfg_valid <= 1'b0;
    settings_used++;
  endtask

  task automatic send_body(input bit end_on_last);
    int i;
    for (i = 0; i < body.size(); i++)
      send_item(body[i], i == 0, end_on_last && i == body.size() - 1, 1'b1);
    strings_sent++;
  endtask

  function automatic logic [7:0] hex_char(logic [3:0] n);
    if (n < 10) return 8'h30 + n;
    return ($urandom_range(0, 1) ? 8'h61 : 8'h41) + n - 10;
  endfunction

  function automatic bit is_hex_char(logic [7:0] b);
    return (b >= 8'h30 && b <= 8'h39) || (b >= 8'h41 && b <= 8'h46) ||
           (b >= 8'h61 && b <= 8'h66);
  endfunction

  function automatic logic [7:0] escape_letter(int idx);
    case (idx)
      0:       return 8'h22;
      1:       return 8'h5C;
      2:       return 8'h2F;
      3:       return 8'h62;
      4:       return 8'h66;
      5:       return 8'h6E;
      6:       return 8'h72;
      default: return 8'h74;
    endcase
  endfunction

  function automatic void add_unicode(logic [15:0] v);
    body.push_back(BACKSLASH);
    body.push_back(LETTER_U);
    body.push_back(hex_char(v[15:12]));
    body.push_back(hex_char(v[11:8]));
    body.push_back(hex_char(v[7:4]));
    body.push_back(hex_char(v[3:0]));
  endfunction

  function automatic void add_plain();
    logic [7:0] c;
    do c = $urandom_range(8'h20, 8'h7E); while (c == QUOTE || c == BACKSLASH);
    body.push_back(c);
  endfunction

  function automatic logic [7:0] random_lead(int len);
    case (len)
      2:       return $urandom_range(8'hC2, 8'hDF);
      3:       return $urandom_range(8'hE0, 8'hEF);
      default: return $urandom_range(8'hF0, 8'hF4);
    endcase
  endfunction

  function automatic logic [15:0] random_unit();
    case ($urandom_range(0, 5))
      0: return $urandom_range(16'h0000, 16'h007F);
      1: return $urandom_range(16'h0080, 16'h07FF);
      2: return $urandom_range(16'h0800, 16'hD7FF);
      3: return $urandom_range(16'hE000, 16'hFFFF);
      4: begin
        case ($urandom_range(0, 7))
          0:       return 16'h0000;
          1:       return 16'h007F;
          2:       return 16'h0080;
          3:       return 16'h07FF;
          4:       return 16'h0800;
          5:       return 16'hD7FF;
          6:       return 16'hE000;
          default: return 16'hFFFF;
        endcase
      end
      default: return $urandom_range(16'hE000, 16'hFFFF) ^ {$urandom_range(0, 1), 15'd0};
    endcase
  endfunction

  function automatic void add_good_token();
    int len;
    int k;
    case ($urandom_range(0, 9))
      0, 1, 2, 3, 9: add_plain();
      4: begin
        len = $urandom_range(2, 4);
        body.push_back(random_lead(len));
        for (k = 1; k < len; k++) body.push_back($urandom_range(8'h80, 8'hBF));
      end
      5: begin
        body.push_back(BACKSLASH);
        body.push_back(escape_letter($urandom_range(0, 7)));
      end
      6, 7: add_unicode(random_unit());
      default: begin
        add_unicode($urandom_range(16'hD800, 16'hDBFF));
        add_unicode($urandom_range(16'hDC00, 16'hDFFF));
      end
    endcase
  endfunction

  function automatic void add_bad_token();
    logic [7:0] b;
    int         k;
    case ($urandom_range(0, 9))
      0: body.push_back($urandom_range(8'h00, 8'h1F));
      1: begin
        case ($urandom_range(0, 2))
          0:       body.push_back($urandom_range(8'h80, 8'hBF));
          1:       body.push_back($urandom_range(8'hC0, 8'hC1));
          default: body.push_back($urandom_range(8'hF5, 8'hFF));
        endcase
      end
      2: begin
        body.push_back(random_lead($urandom_range(2, 4)));
        do b = $urandom_range(0, 255); while (b[7:6] == 2'b10);
        body.push_back(b);
      end
      3: begin
        body.push_back(BACKSLASH);
        do b = $urandom_range(0, 255);
        while (b == LETTER_U || b == 8'h22 || b == 8'h5C || b == 8'h2F || b == 8'h62 ||
               b == 8'h66 || b == 8'h6E || b == 8'h72 || b == 8'h74);
        body.push_back(b);
      end
      4: begin
        body.push_back(BACKSLASH);
        body.push_back(LETTER_U);
        for (k = $urandom_range(0, 3); k > 0; k--) body.push_back(hex_char($urandom_range(0, 15)));
        do b = $urandom_range(0, 255); while (is_hex_char(b));
        body.push_back(b);
      end
      5: add_unicode($urandom_range(16'hDC00, 16'hDFFF));
      6: begin
        add_unicode($urandom_range(16'hD800, 16'hDBFF));
        do b = $urandom_range(0, 255); while (b == BACKSLASH);
        body.push_back(b);
      end
      7: begin
        add_unicode($urandom_range(16'hD800, 16'hDBFF));
        body.push_back(BACKSLASH);
        do b = $urandom_range(0, 255); while (b == LETTER_U);
        body.push_back(b);
      end
      8: begin
        add_unicode($urandom_range(16'hD800, 16'hDBFF));
        add_unicode($urandom_range(0, 1) ? random_unit() : $urandom_range(16'hD800, 16'hDBFF));
      end
      default: begin
        // A quote where a continuation byte belongs.
        body.push_back(random_lead(4));
        body.push_back($urandom_range(8'h80, 8'hBF));
        body.push_back(QUOTE);
      end
    endcase
  endfunction

  task automatic send_string(input int max_tokens, input int noise_pct);
    int  ntok;
    int  ending;
    int  k;
    bit  end_on_last;
    body.delete();
    ntok = $urandom_range(0, max_tokens);
    repeat (ntok) begin
      if ($urandom_range(0, 99) < noise_pct) add_bad_token();
      else add_good_token();
    end
    ending = $urandom_range(0, 19);
    end_on_last = 1'b0;
    if (body.size() == 0 || ending < 15 || ending == 19) begin
      body.push_back(QUOTE);
    end else if (ending < 17) begin
      body.push_back(QUOTE);
      end_on_last = 1'b1;
    end else if (ending == 17) begin
      // Data runs out inside the string, sometimes inside a sequence.
      if (body.size() > 1 && $urandom_range(0, 1)) void'(body.pop_back());
      end_on_last = 1'b1;
    end
    // An ending of 18 leaves the string open; the next start cuts it off.
    send_body(end_on_last);
    if (ending == 19) begin
      for (k = $urandom_range(1, 3); k > 0; k--)
        send_item($urandom_range(0, 255), 1'b0, $urandom_range(0, 1), 1'b0);
    end
  endtask

  task automatic run_strings(input int target, input int max_tokens, input int noise_pct);
    while (items_sent < target) send_string(max_tokens, noise_pct);
  endtask

  initial begin : stimulus
    rst_n <= 1'b0;
    repeat (4) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Directed corners under the reset capacity.
    send_item(8'h41, 1'b0, 1'b0, 1'b0);  // no string open: dropped
    send_item(QUOTE, 1'b1, 1'b0, 1'b1);  // empty string
    send_item(8'h1F, 1'b1, 1'b0, 1'b1);  // highest control byte
    send_item(8'hFF, 1'b1, 1'b0, 1'b1);  // invalid lead byte
    send_item(8'hE2, 1'b1, 1'b1, 1'b1);  // lead byte with no data after it
    send_item(8'h7E, 1'b1, 1'b1, 1'b1);  // data ends inside the string
    body.delete();
    body.push_back(8'hF4);
    body.push_back(8'h8F);
    body.push_back(8'hBF);
    body.push_back(8'hBF);
    add_unicode(16'hDBFF);
    add_unicode(16'hDFFF);
    body.push_back(QUOTE);
    send_body(1'b1);

    set_capacity(16'hFFFF);
    run_strings(130, 8, 15);

    // Block the result side while the input keeps coming.
    hold_requests++;
    steady = 1'b1;
    body.delete();
    repeat (40) add_plain();
    body.push_back(QUOTE);
    send_body(1'b0);
    steady = 1'b0;

    set_capacity(16'd1);
    run_strings(items_sent + 20, 2, 20);
    set_capacity($urandom_range(2, 6));
    run_strings(items_sent + 50, 3, 15);
    set_capacity($urandom_range(7, 40));
    run_strings(items_sent + 70, 10, 10);
    set_capacity(16'hFFFF);
    run_strings(TOTAL_ITEMS, 8, 15);

    wait_for_idle();
    $display("Sent %0d bytes in %0d strings over %0d capacity settings.",
             items_sent, strings_sent, settings_used);
    $display("Checked %0d results; error codes seen, one bit per code: %b.",
             results_checked, codes_seen);
    if (fail_count == 0 && pending == 0) begin
      $display("json_string_unescape: match");
    end else begin
      $display("%0d wrong results, %0d still expected", fail_count, pending);
      $display("json_string_unescape: mismatch");
    end
    $finish;
  end

endmodule
